>>> sv/pcbe_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the cubic Bezier evaluation unit.
package pcbe_pkg;

  // Control point table and field widths.
  localparam int MAX_POINTS = 16;
  localparam int COORD_W    = 24;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int T_W        = 24;
  localparam int FRAC_W     = 16;
  localparam int TINT_W     = T_W - FRAC_W;
  localparam int MOD_SPLIT  = TINT_W / 2;

  // Segments and table rows. Row r of the banks serves segment r.
  localparam int SEG_MAX = (MAX_POINTS - 1) / 3;
  localparam int ROWS    = (MAX_POINTS + 2) / 3;
  localparam int ROW_W   = $clog2(ROWS);

  // Bernstein weights are Q1.48 and may reach exactly 1.0.
  localparam int ONE_Q16 = 1 << FRAC_W;
  localparam int V_W     = FRAC_W + 1;
  localparam int SQ_W    = 2 * FRAC_W + 1;
  localparam int W_FRAC  = 3 * FRAC_W;
  localparam int W_W     = W_FRAC + 1;
  localparam int WL_W    = 24;
  localparam int WH_W    = W_W - WL_W;

  // Pipeline stage numbers.
  localparam int ST_IN   = 1;
  localparam int ST_MID  = 2;
  localparam int ST_WGT  = 3;
  localparam int ST_PROD = 4;
  localparam int ST_SUM  = 5;
  localparam int ST_TOT  = 6;
  localparam int ST_OUT  = 7;

  // Register port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = '0;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } action_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    action_t          action;
    logic [IDX_W-1:0] point_index;
    coord_t           point_x;
    coord_t           point_y;
    coord_t           point_z;
    logic [T_W-1:0]   t_param;
  } in_beat_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   bad_count;
  } out_beat_t;

  typedef logic [W_W-1:0] weight_t;
  typedef weight_t [3:0]  weight4_t;
  typedef coord_t [3:0]   coord4_t;
  typedef point_t [3:0]   point4_t;

  typedef struct packed {
    logic [ST_OUT:ST_IN] load;
    logic [ST_OUT:ST_IN] valid;
  } pipe_ctl_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    point_t           wr_pt;
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
  } store_req_t;

  // Segment count for a point count of the form 3k+4, zero for any other count.
  function automatic logic [ROW_W-1:0] seg_count(input logic [CNT_W-1:0] n);
    logic [ROW_W-1:0] segs;
    segs = '0;
    for (int k = 0; k < SEG_MAX; k++) begin
      if (int'(n) == 3 * k + 4) begin
        segs = ROW_W'(k + 1);
      end
    end
    return segs;
  endfunction

  // Index divided by three, as a multiply by 171/512 (exact below 512).
  function automatic logic [ROW_W-1:0] point_row(input logic [IDX_W-1:0] idx);
    logic [IDX_W+7:0] prod;
    prod = (IDX_W + 8)'(idx) * (IDX_W + 8)'(171);
    return ROW_W'(prod >> 9);
  endfunction

endpackage

>>> sv/pcbe_cfg_regs.sv
`timescale 1ns / 1ps
// Register port holding the control point count.
module pcbe_cfg_regs
  import pcbe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CNT_W-1:0]      point_count
);

  logic [CNT_W-1:0]     point_count_r;
  logic [CNT_W-1:0]     point_count_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_hit;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_hit  = psel && penable && pwrite && (reg_idx == REG_POINT_COUNT);
  assign pready  = 1'b1;

  always_comb begin
    point_count_nxt = point_count_r;
    if (wr_hit) begin
      point_count_nxt = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
    end else begin
      point_count_r <= point_count_nxt;
    end
  end

  assign prdata      = (reg_idx == REG_POINT_COUNT) ? CFG_DATA_W'(point_count_r) : '0;
  assign point_count = point_count_r;

endmodule

>>> sv/pcbe_point_store.sv
`timescale 1ns / 1ps
// Control point table split into four banks so that a segment reads all four points at once.
module pcbe_point_store
  import pcbe_pkg::*;
(
  input  logic       clk,
  input  store_req_t req,
  output point4_t    rd_pts
);

  localparam logic [1:0] PHASE_A = 2'd0;
  localparam logic [1:0] PHASE_B = 2'd1;
  localparam logic [1:0] PHASE_C = 2'd2;

  // Bank a holds points 3r, b holds 3r+1, c holds 3r+2 and d holds 3r+3 (a copy of a's next row).
  point_t bank_a [ROWS];
  point_t bank_b [ROWS];
  point_t bank_c [ROWS];
  point_t bank_d [ROWS];

  point4_t          rd_pts_r;
  logic [ROW_W-1:0] wr_row;
  logic [IDX_W-1:0] wr_base;
  logic [1:0]       wr_phase;

  always_comb begin
    wr_row   = point_row(req.wr_idx);
    wr_base  = IDX_W'({wr_row, 1'b0}) + IDX_W'(wr_row);
    wr_phase = 2'(req.wr_idx - wr_base);
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      case (wr_phase)
        PHASE_A: begin
          bank_a[wr_row] <= req.wr_pt;
          if (wr_row != '0) begin
            bank_d[wr_row - 1'b1] <= req.wr_pt;
          end
        end
        PHASE_B: begin
          bank_b[wr_row] <= req.wr_pt;
        end
        PHASE_C: begin
          bank_c[wr_row] <= req.wr_pt;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_pts_r[0] <= bank_a[req.rd_row];
      rd_pts_r[1] <= bank_b[req.rd_row];
      rd_pts_r[2] <= bank_c[req.rd_row];
      rd_pts_r[3] <= bank_d[req.rd_row];
    end
  end

  assign rd_pts = rd_pts_r;

endmodule

>>> sv/pcbe_front.sv
`timescale 1ns / 1ps
// Front stages: segment selection by modulo, powers of the local parameter and Bernstein weights.
module pcbe_front
  import pcbe_pkg::*;
(
  input  logic             clk,
  input  pipe_ctl_t        ctl,
  input  in_beat_t         in_data,
  input  logic [CNT_W-1:0] point_count,
  output store_req_t       store_req,
  output weight4_t         s3_weight,
  output logic             s3_zero,
  output logic             s3_bad
);

  // Restoring remainder over MOD_SPLIT bits of the integer part; rem stays below segs when segs is nonzero.
  function automatic logic [ROW_W-1:0] mod_steps(input logic [ROW_W-1:0]     rem_in,
                                                 input logic [MOD_SPLIT-1:0] bits,
                                                 input logic [ROW_W-1:0]     segs);
    logic [ROW_W:0]   acc;
    logic [ROW_W-1:0] rem;
    rem = rem_in;
    for (int i = MOD_SPLIT - 1; i >= 0; i--) begin
      acc = {rem, bits[i]};
      if (acc >= {1'b0, segs}) begin
        acc = acc - {1'b0, segs};
      end
      rem = acc[ROW_W-1:0];
    end
    return rem;
  endfunction

  in_beat_t         s1_beat_r;
  logic [ROW_W-1:0] s1_segs_r;

  logic [FRAC_W-1:0] s1_u;
  logic [V_W-1:0]    s1_v;
  logic [SQ_W-1:0]   uu_nxt;
  logic [SQ_W-1:0]   vv_nxt;
  logic [SQ_W-1:0]   uv_nxt;
  logic [ROW_W-1:0]  rem_nxt;
  logic              bad_nxt;

  action_t            s2_action_r;
  logic               s2_bad_r;
  logic [ROW_W-1:0]   s2_segs_r;
  logic [ROW_W-1:0]   s2_rem_r;
  logic [MOD_SPLIT-1:0] s2_tlo_r;
  logic [FRAC_W-1:0]  s2_u_r;
  logic [V_W-1:0]     s2_v_r;
  logic [SQ_W-1:0]    s2_uu_r;
  logic [SQ_W-1:0]    s2_vv_r;
  logic [SQ_W-1:0]    s2_uv_r;
  logic [IDX_W-1:0]   s2_idx_r;
  point_t             s2_pt_r;

  logic [ROW_W-1:0] seg;
  logic [W_W-1:0]   uvv;
  logic [W_W-1:0]   uuv;
  weight4_t         w_nxt;
  weight4_t         w_r;
  logic             zero_r;
  logic             bad_r;

  // Stage one: input register.
  always_ff @(posedge clk) begin
    if (ctl.load[ST_IN]) begin
      s1_beat_r <= in_data;
      s1_segs_r <= seg_count(point_count);
    end
  end

  always_comb begin
    s1_u    = s1_beat_r.t_param[FRAC_W-1:0];
    s1_v    = V_W'(ONE_Q16) - V_W'(s1_u);
    uu_nxt  = SQ_W'(s1_u) * SQ_W'(s1_u);
    vv_nxt  = SQ_W'(s1_v) * SQ_W'(s1_v);
    uv_nxt  = SQ_W'(s1_u) * SQ_W'(s1_v);
    rem_nxt = mod_steps('0, s1_beat_r.t_param[T_W-1 -: MOD_SPLIT], s1_segs_r);
    bad_nxt = (s1_beat_r.action == ACT_EVAL) && (s1_segs_r == '0);
  end

  // Stage two: squares and the partial remainder.
  always_ff @(posedge clk) begin
    if (ctl.load[ST_MID]) begin
      s2_action_r <= s1_beat_r.action;
      s2_bad_r    <= bad_nxt;
      s2_segs_r   <= s1_segs_r;
      s2_rem_r    <= rem_nxt;
      s2_tlo_r    <= s1_beat_r.t_param[FRAC_W +: MOD_SPLIT];
      s2_u_r      <= s1_u;
      s2_v_r      <= s1_v;
      s2_uu_r     <= uu_nxt;
      s2_vv_r     <= vv_nxt;
      s2_uv_r     <= uv_nxt;
      s2_idx_r    <= s1_beat_r.point_index;
      s2_pt_r     <= '{x: s1_beat_r.point_x, y: s1_beat_r.point_y, z: s1_beat_r.point_z};
    end
  end

  always_comb begin
    seg      = mod_steps(s2_rem_r, s2_tlo_r, s2_segs_r);
    uvv      = W_W'(s2_uv_r) * W_W'(s2_v_r);
    uuv      = W_W'(s2_uv_r) * W_W'(s2_u_r);
    w_nxt[0] = W_W'(s2_vv_r) * W_W'(s2_v_r);
    w_nxt[1] = {uvv[W_W-2:0], 1'b0} + uvv;
    w_nxt[2] = {uuv[W_W-2:0], 1'b0} + uuv;
    w_nxt[3] = W_W'(s2_uu_r) * W_W'(s2_u_r);
  end

  // Table writes and reads both happen as a beat leaves stage two, which keeps them in order.
  always_comb begin
    store_req.wr_en  = ctl.load[ST_WGT] && ctl.valid[ST_MID] && (s2_action_r == ACT_WRITE) &&
                       (int'(s2_idx_r) < MAX_POINTS);
    store_req.wr_idx = s2_idx_r;
    store_req.wr_pt  = s2_pt_r;
    store_req.rd_en  = ctl.load[ST_WGT];
    store_req.rd_row = seg;
  end

  // Stage three: weights.
  always_ff @(posedge clk) begin
    if (ctl.load[ST_WGT]) begin
      w_r    <= w_nxt;
      zero_r <= (s2_action_r == ACT_WRITE) || s2_bad_r;
      bad_r  <= s2_bad_r;
    end
  end

  assign s3_weight = w_r;
  assign s3_zero   = zero_r;
  assign s3_bad    = bad_r;

endmodule

>>> sv/pcbe_blend.sv
`timescale 1ns / 1ps
// Back stages for one axis: weight times coordinate, sums and truncation toward zero.
module pcbe_blend
  import pcbe_pkg::*;
(
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  weight4_t  weight,
  input  coord4_t   coord,
  output coord_t    result
);

  localparam int HI_W   = WH_W + 1 + COORD_W;
  localparam int LO_W   = WL_W + 1 + COORD_W;
  localparam int HSUM_W = HI_W + 2;
  localparam int LSUM_W = LO_W + 2;
  localparam int TOT_W  = HSUM_W + WL_W;

  logic signed [HI_W-1:0]   hi_nxt [4];
  logic signed [LO_W-1:0]   lo_nxt [4];
  logic signed [HI_W-1:0]   hi_r   [4];
  logic signed [LO_W-1:0]   lo_r   [4];
  logic signed [HSUM_W-1:0] hsum_nxt;
  logic signed [LSUM_W-1:0] lsum_nxt;
  logic signed [HSUM_W-1:0] hsum_r;
  logic signed [LSUM_W-1:0] lsum_r;
  logic signed [TOT_W-1:0]  total_nxt;
  logic signed [TOT_W-1:0]  total_r;
  logic [COORD_W-1:0]       floor_q;
  logic                     round_up;
  coord_t                   result_nxt;
  coord_t                   result_r;

  // Weights are split into high and low halves to keep each multiplier narrow.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hi_nxt[k] = HI_W'($signed({1'b0, weight[k][W_W-1 -: WH_W]})) *
                  HI_W'($signed(coord[k]));
      lo_nxt[k] = LO_W'($signed({1'b0, weight[k][WL_W-1:0]})) *
                  LO_W'($signed(coord[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[ST_PROD]) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  always_comb begin
    hsum_nxt = (HSUM_W'(hi_r[0]) + HSUM_W'(hi_r[1])) + (HSUM_W'(hi_r[2]) + HSUM_W'(hi_r[3]));
    lsum_nxt = (LSUM_W'(lo_r[0]) + LSUM_W'(lo_r[1])) + (LSUM_W'(lo_r[2]) + LSUM_W'(lo_r[3]));
  end

  always_ff @(posedge clk) begin
    if (ctl.load[ST_SUM]) begin
      hsum_r <= hsum_nxt;
      lsum_r <= lsum_nxt;
    end
  end

  assign total_nxt = (TOT_W'(hsum_r) <<< WL_W) + TOT_W'(lsum_r);

  always_ff @(posedge clk) begin
    if (ctl.load[ST_TOT]) begin
      total_r <= total_nxt;
    end
  end

  // Floor of the exact sum, moved up by one for a negative value with a fractional part.
  always_comb begin
    floor_q    = total_r[W_FRAC +: COORD_W];
    round_up   = total_r[TOT_W-1] && (|total_r[W_FRAC-1:0]);
    result_nxt = floor_q + COORD_W'(round_up);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[ST_OUT]) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

>>> sv/piecewise_cubic_bezier_eval_unit.sv
`timescale 1ns / 1ps
// Top level of the piecewise cubic Bezier evaluation unit.
//
// A beat on the in_ channel either writes one control point into the table
// (action write) or evaluates the curve at t_param (action evaluate). Every
// beat gives exactly one beat on the out_ channel, in order; a write and an
// evaluate with an unusable point count give zero coordinates, the latter
// with bad_count set. The point count is set through the register port at
// address 0; the user must change it only while no beat is in flight, which
// the block does not enforce. The datapath is a seven stage pipeline, and
// one beat is taken every cycle as long as the receiver does not stall. The
// three multiplier stages, the two adder stages and the final rounding set
// the depth. When out_stall is high, the pipeline closes its empty slots
// first and only then stalls the input; nothing is dropped or repeated.
// Synchronous reset clears the stage valid bits and the point count; the
// table keeps its contents and an entry holds no defined value until it is
// written.
module piecewise_cubic_bezier_eval_unit
  import pcbe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [ST_OUT:ST_IN]   valid_r;
  logic [ST_OUT:ST_IN]   valid_nxt;
  logic [ST_OUT:ST_IN]   load;
  pipe_ctl_t             ctl;
  logic [CNT_W-1:0]      point_count;
  store_req_t            store_req;
  point4_t               rd_pts;
  weight4_t              s3_weight;
  logic                  s3_zero;
  logic                  s3_bad;
  coord4_t               coord_x;
  coord4_t               coord_y;
  coord4_t               coord_z;
  coord_t                res_x;
  coord_t                res_y;
  coord_t                res_z;
  logic [ST_OUT:ST_PROD] zero_r;
  logic [ST_OUT:ST_PROD] bad_r;

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    load[ST_OUT] = !valid_r[ST_OUT] || !out_stall;
    for (int k = ST_OUT - 1; k >= ST_IN; k--) begin
      load[k] = !valid_r[k] || load[k+1];
    end
  end

  always_comb begin
    valid_nxt[ST_IN] = load[ST_IN] ? in_valid : valid_r[ST_IN];
    for (int k = ST_IN + 1; k <= ST_OUT; k++) begin
      valid_nxt[k] = load[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ctl.load  = load;
  assign ctl.valid = valid_r;

  pcbe_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .point_count (point_count)
  );

  pcbe_front u_front (
    .clk         (clk),
    .ctl         (ctl),
    .in_data     (in_data),
    .point_count (point_count),
    .store_req   (store_req),
    .s3_weight   (s3_weight),
    .s3_zero     (s3_zero),
    .s3_bad      (s3_bad)
  );

  pcbe_point_store u_point_store (
    .clk    (clk),
    .req    (store_req),
    .rd_pts (rd_pts)
  );

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      coord_x[k] = rd_pts[k].x;
      coord_y[k] = rd_pts[k].y;
      coord_z[k] = rd_pts[k].z;
    end
  end

  pcbe_blend u_blend_x (
    .clk    (clk),
    .ctl    (ctl),
    .weight (s3_weight),
    .coord  (coord_x),
    .result (res_x)
  );

  pcbe_blend u_blend_y (
    .clk    (clk),
    .ctl    (ctl),
    .weight (s3_weight),
    .coord  (coord_y),
    .result (res_y)
  );

  pcbe_blend u_blend_z (
    .clk    (clk),
    .ctl    (ctl),
    .weight (s3_weight),
    .coord  (coord_z),
    .result (res_z)
  );

  // Result flags follow the beat through the back stages.
  always_ff @(posedge clk) begin
    if (load[ST_PROD]) begin
      zero_r[ST_PROD] <= s3_zero;
      bad_r[ST_PROD]  <= s3_bad;
    end
    for (int k = ST_PROD + 1; k <= ST_OUT; k++) begin
      if (load[k]) begin
        zero_r[k] <= zero_r[k-1];
        bad_r[k]  <= bad_r[k-1];
      end
    end
  end

  assign in_stall  = !load[ST_IN];
  assign out_valid = valid_r[ST_OUT];

  always_comb begin
    out_data.out_x     = zero_r[ST_OUT] ? '0 : res_x;
    out_data.out_y     = zero_r[ST_OUT] ? '0 : res_y;
    out_data.out_z     = zero_r[ST_OUT] ? '0 : res_z;
    out_data.bad_count = bad_r[ST_OUT];
  end

endmodule

>>> sv/pcbe_checker.sv
`timescale 1ns / 1ps
// Port level checks of the evaluation unit and their binding to the top level.
module pcbe_checker
  import pcbe_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  // A stalled result beat stays and does not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed or vanished while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // With the receiver taking beats, the input never stalls.
  a_no_stall_through: assert property (@(posedge clk)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output was free");

  // A bad point count answers with zero coordinates.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_count |->
      out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0)
    else $error("bad point count gave nonzero coordinates");

  // Free cycles without an input beat drain every stage.
  a_idle_in: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_valid && !out_stall) [*7] |=> !out_valid)
    else $error("result beat without an input beat");

endmodule

bind piecewise_cubic_bezier_eval_unit pcbe_checker u_pcbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> sim/tb_piecewise_cubic_bezier_eval_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the piecewise cubic Bezier evaluation unit.
module tb_piecewise_cubic_bezier_eval_unit;
  import pcbe_pkg::*;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = 24'sh800000;
  localparam int     PIPE_LAT  = 7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  piecewise_cubic_bezier_eval_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: its own copy of the point table and the point count.
  coord_t    ctrl_pts [MAX_POINTS][3];
  int        pt_count = 0;

  in_beat_t  beats_to_send [$];
  out_beat_t curve_due [$];
  int        mismatches = 0;
  logic      in_took = 1'b0;

  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  int phase_counts [13] = '{16, 4, 31, 7, 1, 10, 13, 5, 0, 16, 3, 4, 16};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Exact Bernstein-weighted sum of four coordinates, truncated toward zero.
  function automatic coord_t bezier_coord(input logic [FRAC_W-1:0] frac,
                                          input coord_t p [4]);
    logic signed [79:0] uu, vv, acc, pv, den;
    logic signed [79:0] wts [4];
    uu = {64'd0, frac};
    vv = 80'sd65536 - uu;
    wts[0] = vv * vv * vv;
    wts[1] = 3 * uu * vv * vv;
    wts[2] = 3 * uu * uu * vv;
    wts[3] = uu * uu * uu;
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      pv = $signed(p[k]);
      acc = acc + wts[k] * pv;
    end
    den = 80'sd1 <<< 48;
    acc = acc / den;
    return acc[COORD_W-1:0];
  endfunction

  function automatic out_beat_t predict_curve_beat(input in_beat_t b);
    out_beat_t r;
    coord_t    p [4];
    int        segs, seg, base;
    r = '0;
    if (b.action == ACT_WRITE) begin
      ctrl_pts[b.point_index][0] = b.point_x;
      ctrl_pts[b.point_index][1] = b.point_y;
      ctrl_pts[b.point_index][2] = b.point_z;
    end else if (pt_count < 4 || (pt_count - 4) % 3 != 0 || pt_count > MAX_POINTS) begin
      r.bad_count = 1'b1;
    end else begin
      segs = (pt_count - 1) / 3;
      seg  = int'(b.t_param[T_W-1:FRAC_W]) % segs;
      base = seg * 3;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) p[k] = ctrl_pts[base + k][c];
        case (c)
          0: r.out_x = bezier_coord(b.t_param[FRAC_W-1:0], p);
          1: r.out_y = bezier_coord(b.t_param[FRAC_W-1:0], p);
          default: r.out_z = bezier_coord(b.t_param[FRAC_W-1:0], p);
        endcase
      end
    end
    return r;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Mostly random parameters, with the zero and full fractions mixed in.
  function automatic logic [T_W-1:0] rand_t();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1: return {r[7:0], 16'h0000};
      2: return {r[7:0], 16'hFFFF};
      default: return r[T_W-1:0];
    endcase
  endfunction

  function automatic in_beat_t write_beat(input logic [IDX_W-1:0] slot,
                                          input coord_t x, input coord_t y,
                                          input coord_t z);
    in_beat_t b;
    b.action      = ACT_WRITE;
    b.point_index = slot;
    b.point_x     = x;
    b.point_y     = y;
    b.point_z     = z;
    b.t_param     = T_W'($urandom);
    return b;
  endfunction

  function automatic in_beat_t eval_beat(input logic [T_W-1:0] t);
    in_beat_t b;
    b = write_beat(IDX_W'($urandom), rand_coord(), rand_coord(), rand_coord());
    b.action  = ACT_EVAL;
    b.t_param = t;
    return b;
  endfunction

  // Appends one beat to the sender's queue.
  task automatic queue_beat(input in_beat_t b);
    beats_to_send.insert(beats_to_send.size(), b);
  endtask

  task automatic set_point_count(input int n);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = CFG_ADDR_W'({REG_POINT_COUNT, 2'b00});
    pwdata  = CFG_DATA_W'(n);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    pt_count = n;
  endtask

  // Returns once every queued beat has gone out and every result is back.
  task automatic wait_drained();
    while (beats_to_send.size() != 0 || in_valid || curve_due.size() != 0)
      @(negedge clk);
    repeat (PIPE_LAT + 3) @(negedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (beats_to_send.size() > 0) begin
        in_data  <= beats_to_send.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 20);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: the stall pattern switches among free running, random and periodic.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(30, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 35);
      default: out_stall <= (stall_tick % 9) < 4;
    endcase
    stall_tick <= stall_tick + 1;
  end

  // Input beats feed the predictor; output beats are checked in order.
  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      curve_due.insert(curve_due.size(), predict_curve_beat(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (curve_due.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("%0t: output beat with nothing expected: x=%0d y=%0d z=%0d bad=%0b",
                   $realtime, out_data.out_x, out_data.out_y, out_data.out_z,
                   out_data.bad_count);
      end else if (out_data !== curve_due[0]) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected x=%0d y=%0d z=%0d bad=%0b, got x=%0d y=%0d z=%0d bad=%0b",
                   $realtime, curve_due[0].out_x, curve_due[0].out_y,
                   curve_due[0].out_z, curve_due[0].bad_count, out_data.out_x,
                   out_data.out_y, out_data.out_z, out_data.bad_count);
        void'(curve_due.pop_front());
      end else begin
        void'(curve_due.pop_front());
      end
    end
  end

  initial begin
    for (int i = 0; i < MAX_POINTS; i++)
      for (int c = 0; c < 3; c++) ctrl_pts[i][c] = '0;
    rst_n = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Fill the whole table first so no evaluate ever reads an unwritten slot.
    // The first segment gets the coordinate extremes.
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (i < 4)
        queue_beat(write_beat(IDX_W'(i), COORD_MAX, COORD_MIN,
                              (i % 2 == 0) ? COORD_MAX : COORD_MIN));
      else
        queue_beat(write_beat(IDX_W'(i), rand_coord(), rand_coord(), rand_coord()));
    end
    // Point count still at its reset value of zero, so this one is flagged.
    queue_beat(eval_beat(24'h012345));
    wait_drained();

    set_point_count(MAX_POINTS);
    queue_beat(eval_beat(24'h000000));
    queue_beat(eval_beat(24'h00FFFF));
    queue_beat(eval_beat(24'h008000));
    queue_beat(eval_beat(24'hFFFFFF));
    queue_beat(eval_beat(24'h050000));
    queue_beat(eval_beat(24'h04C000));
    wait_drained();

    foreach (phase_counts[p]) begin
      set_point_count(phase_counts[p]);
      repeat (125) begin
        if ($urandom_range(0, 4) == 0)
          queue_beat(write_beat(IDX_W'($urandom), rand_coord(), rand_coord(),
                                rand_coord()));
        else
          queue_beat(eval_beat(rand_t()));
      end
      wait_drained();
    end

    repeat (3 * PIPE_LAT) @(negedge clk);
    if (mismatches == 0 && curve_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
sv/pcbe_pkg.sv
sv/pcbe_cfg_regs.sv
sv/pcbe_point_store.sv
sv/pcbe_front.sv
sv/pcbe_blend.sv
sv/piecewise_cubic_bezier_eval_unit.sv
sv/pcbe_checker.sv
sim/tb_piecewise_cubic_bezier_eval_unit.sv
